@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the parser RTL.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, cond) \
  `ASSERT_CLK(label, !(cond))

`endif

@@ hw/rtl/v6p_pkg.sv @@
// Package for the IPv6 text address parser.
// Types and constants shared by front, queue and scanner; no dependencies.
package v6p_pkg;

  localparam int unsigned MAX_GROUPS  = 8;
  localparam int unsigned MAX_DIGITS  = 4;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_END   = 8'h00;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_LEAD_COLON  = 3'd1,
    PH_AFTER_GAP   = 3'd2,
    PH_AFTER_COLON = 3'd3,
    PH_IN_GROUP    = 3'd4
  } phase_t;

  typedef struct packed {
    logic       is_end;
    logic       is_colon;
    logic       is_hex;
    logic [3:0] hex_val;
  } char_item_t;

endpackage

@@ hw/rtl/ipv6_text_address_parser_unit.sv @@
// IPv6 text address parser, top level.
// Depends on v6p_pkg, v6p_front, v6p_queue and v6p_scan.
//
// Usage:
//   Input channel (in_valid/in_ready/in_char_code) takes one text byte per
//   item. A zero byte ends the string and yields one result item on the
//   output channel (out_valid/out_ready/out_addr_valid/out_addr_high/
//   out_addr_low); other bytes yield nothing.
//   out_addr_high holds groups 0..3 (group 0 on top), out_addr_low groups
//   4..7. An invalid text gives out_addr_valid = 0 and a zero address.
//   Throughput: one byte per cycle while in_ready is high. A zero byte is
//   first written into the queue; once it reaches the head of the queue and
//   no result waits or out_ready is high, the scanner pops it and the result
//   register takes the address.
//   Stall: while a result waits on out_ready, further non-zero bytes are
//   still scanned; the next zero byte waits in the queue, and once the queue
//   holds two items in_ready drops.
//   Reset: synchronous, active low; clears the queue, scan state and the
//   result valid. Scan state also returns to start after every result.
module ipv6_text_address_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_addr_valid,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low
);

  logic                q_full;
  logic                push;
  v6p_pkg::char_item_t push_item;
  logic                pop;
  logic                q_valid;
  v6p_pkg::char_item_t q_item;

  v6p_front u_front (
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_ready     (in_ready),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item)
  );

  v6p_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  v6p_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_addr_valid (out_addr_valid),
    .out_addr_high  (out_addr_high),
    .out_addr_low   (out_addr_low)
  );

endmodule

@@ hw/rtl/v6p_front.sv @@
// Front end: input handshake and character classification.
// Depends on v6p_pkg; feeds v6p_queue.
module v6p_front (
  input  logic                in_valid,
  input  logic [7:0]          in_char_code,
  output logic                in_ready,
  input  logic                q_full,
  output logic                push,
  output v6p_pkg::char_item_t push_item
);

  logic [7:0] c;

  assign c        = in_char_code;
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.is_end   = (c == v6p_pkg::CHAR_END);
    push_item.is_colon = (c == v6p_pkg::CHAR_COLON);
    push_item.is_hex   = 1'b1;
    push_item.hex_val  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      push_item.hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      push_item.hex_val = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      push_item.is_hex = 1'b0;
    end
  end

endmodule

@@ hw/rtl/v6p_queue.sv @@
// Two-entry queue of classified items between front and scanner.
// Depends on v6p_pkg and assert_macros.svh.
`include "assert_macros.svh"
module v6p_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  v6p_pkg::char_item_t push_item,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output v6p_pkg::char_item_t q_item
);

  localparam int unsigned CW = $clog2(v6p_pkg::QUEUE_DEPTH + 1);
  localparam int unsigned PW = $clog2(v6p_pkg::QUEUE_DEPTH);

  v6p_pkg::char_item_t mem_r [v6p_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CW'(v6p_pkg::QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(v6p_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(v6p_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `ASSERT_NEVER(a_pop_empty, pop && !q_valid)
  `ASSERT_CLK(a_count_track, (push && !pop) |=> (count_r == $past(count_r) + 1'b1))

endmodule

@@ hw/rtl/v6p_scan.sv @@
// Back end: scan state per character, gap expansion and result register.
// Depends on v6p_pkg and assert_macros.svh.
`include "assert_macros.svh"
module v6p_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  v6p_pkg::char_item_t q_item,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_addr_valid,
  output logic [63:0]         out_addr_high,
  output logic [63:0]         out_addr_low
);

  logic [15:0]      store_r [v6p_pkg::MAX_GROUPS];
  logic [15:0]      store_nxt [v6p_pkg::MAX_GROUPS];
  logic [3:0]       count_r, count_nxt;
  logic             gap_seen_r, gap_seen_nxt;
  logic [3:0]       gap_pos_r, gap_pos_nxt;
  logic [15:0]      digit_r, digit_nxt;
  logic [2:0]       dcount_r, dcount_nxt;
  v6p_pkg::phase_t  phase_r, phase_nxt;
  logic             err_r, err_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_addr_valid_r;
  logic [63:0]      out_addr_high_r, out_addr_low_r;

  logic [15:0]      fin_store [v6p_pkg::MAX_GROUPS];
  logic [15:0]      fin_g [v6p_pkg::MAX_GROUPS];
  logic [3:0]       fin_n;
  logic [3:0]       zeros;
  logic             fin_ok;
  logic [127:0]     fin_addr;
  logic             pop_end;

  assign pop     = q_valid && (!q_item.is_end || !out_valid_r || out_ready);
  assign pop_end = pop && q_item.is_end;

  // Start a group with its first digit, or flag an error when all groups are used.
  function automatic void begin_group(
    input  logic [3:0]      cnt,
    input  logic [3:0]      hv,
    output logic            err,
    output logic [15:0]     dig,
    output logic [2:0]      dcnt,
    output v6p_pkg::phase_t ph,
    input  logic [15:0]     dig_in,
    input  logic [2:0]      dcnt_in,
    input  v6p_pkg::phase_t ph_in
  );
    err  = 1'b0;
    dig  = dig_in;
    dcnt = dcnt_in;
    ph   = ph_in;
    if (cnt >= 4'(v6p_pkg::MAX_GROUPS)) begin
      err = 1'b1;
    end else begin
      dig  = {12'd0, hv};
      dcnt = 3'd1;
      ph   = v6p_pkg::PH_IN_GROUP;
    end
  endfunction

  always_comb begin
    logic bg_err;
    store_nxt    = store_r;
    count_nxt    = count_r;
    gap_seen_nxt = gap_seen_r;
    gap_pos_nxt  = gap_pos_r;
    digit_nxt    = digit_r;
    dcount_nxt   = dcount_r;
    phase_nxt    = phase_r;
    err_nxt      = err_r;
    bg_err       = 1'b0;
    if (pop_end) begin
      count_nxt    = '0;
      gap_seen_nxt = 1'b0;
      gap_pos_nxt  = '0;
      digit_nxt    = '0;
      dcount_nxt   = '0;
      phase_nxt    = v6p_pkg::PH_START;
      err_nxt      = 1'b0;
    end else if (pop && !err_r) begin
      unique case (phase_r)
        v6p_pkg::PH_START: begin
          if (q_item.is_colon) begin
            phase_nxt = v6p_pkg::PH_LEAD_COLON;
          end else if (q_item.is_hex) begin
            begin_group(count_r, q_item.hex_val, bg_err, digit_nxt, dcount_nxt, phase_nxt,
                        digit_r, dcount_r, phase_r);
            err_nxt = bg_err;
          end else begin
            err_nxt = 1'b1;
          end
        end
        v6p_pkg::PH_LEAD_COLON: begin
          if (q_item.is_colon) begin
            gap_seen_nxt = 1'b1;
            gap_pos_nxt  = '0;
            phase_nxt    = v6p_pkg::PH_AFTER_GAP;
          end else begin
            err_nxt = 1'b1;
          end
        end
        v6p_pkg::PH_AFTER_GAP: begin
          if (q_item.is_hex) begin
            begin_group(count_r, q_item.hex_val, bg_err, digit_nxt, dcount_nxt, phase_nxt,
                        digit_r, dcount_r, phase_r);
            err_nxt = bg_err;
          end else begin
            err_nxt = 1'b1;
          end
        end
        v6p_pkg::PH_AFTER_COLON: begin
          if (q_item.is_colon) begin
            if (gap_seen_r) begin
              err_nxt = 1'b1;
            end else begin
              gap_seen_nxt = 1'b1;
              gap_pos_nxt  = count_r;
              phase_nxt    = v6p_pkg::PH_AFTER_GAP;
            end
          end else if (q_item.is_hex) begin
            begin_group(count_r, q_item.hex_val, bg_err, digit_nxt, dcount_nxt, phase_nxt,
                        digit_r, dcount_r, phase_r);
            err_nxt = bg_err;
          end else begin
            err_nxt = 1'b1;
          end
        end
        v6p_pkg::PH_IN_GROUP: begin
          if (q_item.is_hex) begin
            if (dcount_r >= 3'(v6p_pkg::MAX_DIGITS)) begin
              err_nxt = 1'b1;
            end else begin
              digit_nxt  = {digit_r[11:0], q_item.hex_val};
              dcount_nxt = dcount_r + 3'd1;
            end
          end else if (q_item.is_colon) begin
            store_nxt[count_r[2:0]] = digit_r;
            count_nxt  = count_r + 4'd1;
            digit_nxt  = '0;
            dcount_nxt = '0;
            phase_nxt  = v6p_pkg::PH_AFTER_COLON;
          end else begin
            err_nxt = 1'b1;
          end
        end
        default: begin
          err_nxt = 1'b1;
        end
      endcase
    end
  end

  // Final commit and gap expansion.
  always_comb begin
    fin_store = store_r;
    fin_n     = count_r;
    fin_ok    = !err_r;
    zeros     = '0;
    for (int j = 0; j < v6p_pkg::MAX_GROUPS; j++) begin
      fin_g[j] = '0;
    end
    if (fin_ok) begin
      if (phase_r == v6p_pkg::PH_IN_GROUP) begin
        fin_store[count_r[2:0]] = digit_r;
        fin_n = count_r + 4'd1;
      end else if (phase_r != v6p_pkg::PH_AFTER_GAP) begin
        fin_ok = 1'b0;
      end
    end
    if (fin_ok) begin
      if (gap_seen_r) begin
        if (fin_n > 4'(v6p_pkg::MAX_GROUPS) || gap_pos_r > fin_n) begin
          fin_ok = 1'b0;
        end else begin
          zeros = 4'(v6p_pkg::MAX_GROUPS) - fin_n;
          for (int j = 0; j < v6p_pkg::MAX_GROUPS; j++) begin
            if (4'(j) < gap_pos_r) begin
              fin_g[j] = fin_store[j];
            end else if (4'(j) >= gap_pos_r + zeros) begin
              fin_g[j] = fin_store[3'(4'(j) - zeros)];
            end
          end
        end
      end else if (fin_n == 4'(v6p_pkg::MAX_GROUPS)) begin
        fin_g = fin_store;
      end else begin
        fin_ok = 1'b0;
      end
    end
    for (int j = 0; j < v6p_pkg::MAX_GROUPS; j++) begin
      fin_addr[127 - 16*j -: 16] = fin_ok ? fin_g[j] : 16'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop_end) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      gap_seen_r  <= 1'b0;
      gap_pos_r   <= '0;
      digit_r     <= '0;
      dcount_r    <= '0;
      phase_r     <= v6p_pkg::PH_START;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      gap_seen_r  <= gap_seen_nxt;
      gap_pos_r   <= gap_pos_nxt;
      digit_r     <= digit_nxt;
      dcount_r    <= dcount_nxt;
      phase_r     <= phase_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    store_r <= store_nxt;
    if (pop_end) begin
      out_addr_valid_r <= fin_ok;
      out_addr_high_r  <= fin_addr[127:64];
      out_addr_low_r   <= fin_addr[63:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_addr_valid = out_addr_valid_r;
  assign out_addr_high  = out_addr_high_r;
  assign out_addr_low   = out_addr_low_r;

  `ASSERT_CLK(a_clear_after_end,
              pop_end |=> (phase_r == v6p_pkg::PH_START && count_r == '0 && !err_r))
  `ASSERT_NEVER(a_invalid_nonzero,
                out_valid_r && !out_addr_valid_r &&
                (out_addr_high_r != '0 || out_addr_low_r != '0))

endmodule

@@ test/ipv6_text_address_parser_checker.sv @@
`timescale 1ns / 1ps
// Checker for the IPv6 text address parser: watches both channels, predicts
// each address result from the accepted characters and compares it field by field.
// Depends on v6p_pkg.
module ipv6_text_address_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_char_code,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_addr_valid,
  input  logic [63:0] out_addr_high,
  input  logic [63:0] out_addr_low,
  output int          err_count,
  output int          awaiting,
  output int          addr_checked,
  output int          addr_good
);

  typedef struct {
    logic        ok;
    logic [63:0] high;
    logic [63:0] low;
  } addr_result_t;

  addr_result_t addr_expect_q[$];

  logic [15:0]     grp [v6p_pkg::MAX_GROUPS];
  logic [3:0]      grp_cnt;
  logic            gap_seen;
  logic [3:0]      gap_pos;
  logic [15:0]     dig_val;
  logic [2:0]      dig_cnt;
  v6p_pkg::phase_t phase;
  logic            scan_err;

  // {is_hex, value}
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  task automatic clear_scan();
    for (int i = 0; i < v6p_pkg::MAX_GROUPS; i++) grp[i] = '0;
    grp_cnt  = '0;
    gap_seen = 1'b0;
    gap_pos  = '0;
    dig_val  = '0;
    dig_cnt  = '0;
    phase    = v6p_pkg::PH_START;
    scan_err = 1'b0;
  endtask

  task automatic open_group(input logic [3:0] v);
    if (grp_cnt >= v6p_pkg::MAX_GROUPS) begin
      scan_err = 1'b1;
    end else begin
      dig_val = {12'h000, v};
      dig_cnt = 3'd1;
      phase   = v6p_pkg::PH_IN_GROUP;
    end
  endtask

  task automatic commit_group();
    grp[grp_cnt[2:0]] = dig_val;
    grp_cnt = grp_cnt + 4'd1;
    dig_val = '0;
    dig_cnt = '0;
  endtask

  task automatic close_address();
    logic         ok;
    logic [15:0]  g [v6p_pkg::MAX_GROUPS];
    int           n;
    int           pos;
    int           zeros;
    addr_result_t r;
    ok = !scan_err;
    for (int i = 0; i < v6p_pkg::MAX_GROUPS; i++) g[i] = '0;
    if (ok) begin
      if (phase == v6p_pkg::PH_IN_GROUP) commit_group();
      else if (phase != v6p_pkg::PH_AFTER_GAP) ok = 1'b0;
    end
    if (ok) begin
      if (gap_seen) begin
        n   = grp_cnt;
        pos = gap_pos;
        if (n > v6p_pkg::MAX_GROUPS || pos > n) begin
          ok = 1'b0;
        end else begin
          zeros = v6p_pkg::MAX_GROUPS - n;
          for (int i = 0; i < pos; i++) g[i] = grp[i];
          for (int i = pos; i < n; i++) g[(i + zeros) % v6p_pkg::MAX_GROUPS] = grp[i];
        end
      end else if (grp_cnt == v6p_pkg::MAX_GROUPS) begin
        for (int i = 0; i < v6p_pkg::MAX_GROUPS; i++) g[i] = grp[i];
      end else begin
        ok = 1'b0;
      end
    end
    r.ok   = ok;
    r.high = ok ? {g[0], g[1], g[2], g[3]} : 64'd0;
    r.low  = ok ? {g[4], g[5], g[6], g[7]} : 64'd0;
    addr_expect_q.push_back(r);
    clear_scan();
  endtask

  task automatic scan_char(input logic [7:0] c);
    logic [4:0] hx;
    hx = hex_of(c);
    if (c == v6p_pkg::CHAR_END) begin
      close_address();
    end else if (!scan_err) begin
      case (phase)
        v6p_pkg::PH_START: begin
          if (c == v6p_pkg::CHAR_COLON) phase = v6p_pkg::PH_LEAD_COLON;
          else if (hx[4]) open_group(hx[3:0]);
          else scan_err = 1'b1;
        end
        v6p_pkg::PH_LEAD_COLON: begin
          if (c == v6p_pkg::CHAR_COLON) begin
            gap_seen = 1'b1;
            gap_pos  = '0;
            phase    = v6p_pkg::PH_AFTER_GAP;
          end else begin
            scan_err = 1'b1;
          end
        end
        v6p_pkg::PH_AFTER_GAP: begin
          if (hx[4]) open_group(hx[3:0]);
          else scan_err = 1'b1;
        end
        v6p_pkg::PH_AFTER_COLON: begin
          if (c == v6p_pkg::CHAR_COLON) begin
            if (gap_seen) begin
              scan_err = 1'b1;
            end else begin
              gap_seen = 1'b1;
              gap_pos  = grp_cnt;
              phase    = v6p_pkg::PH_AFTER_GAP;
            end
          end else if (hx[4]) begin
            open_group(hx[3:0]);
          end else begin
            scan_err = 1'b1;
          end
        end
        v6p_pkg::PH_IN_GROUP: begin
          if (hx[4]) begin
            if (dig_cnt >= v6p_pkg::MAX_DIGITS) begin
              scan_err = 1'b1;
            end else begin
              dig_val = {dig_val[11:0], hx[3:0]};
              dig_cnt = dig_cnt + 3'd1;
            end
          end else if (c == v6p_pkg::CHAR_COLON) begin
            commit_group();
            phase = v6p_pkg::PH_AFTER_COLON;
          end else begin
            scan_err = 1'b1;
          end
        end
        default: scan_err = 1'b1;
      endcase
    end
  endtask

  task automatic note_failure();
    err_count = err_count + 1;
  endtask

  task automatic check_address();
    addr_result_t e;
    if (addr_expect_q.size() == 0) begin
      note_failure();
      if (err_count <= 10)
        $display("unexpected result item: valid %0b high %h low %h",
                 out_addr_valid, out_addr_high, out_addr_low);
    end else begin
      e = addr_expect_q.pop_front();
      addr_checked = addr_checked + 1;
      if (out_addr_valid) addr_good = addr_good + 1;
      if (out_addr_valid !== e.ok || out_addr_high !== e.high || out_addr_low !== e.low) begin
        note_failure();
        if (err_count <= 10)
          $display({"mismatch on result %0d: valid exp %0b got %0b, ",
                    "high exp %h got %h, low exp %h got %h"},
                   addr_checked, e.ok, out_addr_valid, e.high, out_addr_high,
                   e.low, out_addr_low);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_scan();
      addr_expect_q.delete();
      err_count    = 0;
      addr_checked = 0;
      addr_good    = 0;
    end else begin
      if (out_valid && out_ready) check_address();
      if (in_valid && in_ready) scan_char(in_char_code);
    end
    awaiting = addr_expect_q.size();
  end

endmodule

@@ test/ipv6_text_address_parser_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for ipv6_text_address_parser_unit: drives address texts,
// directed then random, under several idle/stall phases; verdict from the checker.
// Depends on v6p_pkg, the parser RTL and ipv6_text_address_parser_checker.
module ipv6_text_address_parser_unit_tb;

  localparam int CHAR_TARGET = 1700;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_char_code;
  logic        out_valid;
  logic        out_ready;
  logic        out_addr_valid;
  logic [63:0] out_addr_high;
  logic [63:0] out_addr_low;

  int err_count;
  int awaiting;
  int addr_checked;
  int addr_good;

  int cycle_count = 0;
  int sender_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_cycles = 0;
  int chars_sent = 0;
  int texts_sent = 0;

  logic [7:0] text_q[$];

  ipv6_text_address_parser_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_addr_valid(out_addr_valid),
    .out_addr_high (out_addr_high),
    .out_addr_low  (out_addr_low)
  );

  ipv6_text_address_parser_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_addr_valid(out_addr_valid),
    .out_addr_high (out_addr_high),
    .out_addr_low  (out_addr_low),
    .err_count     (err_count),
    .awaiting      (awaiting),
    .addr_checked  (addr_checked),
    .addr_good     (addr_good)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i]);
    send_char(v6p_pkg::CHAR_END);
    texts_sent++;
  endtask

  task automatic send_literal(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_text();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(v) - 8'd10;
  endfunction

  task automatic push_group();
    int kind;
    int ndig;
    kind = $urandom_range(0, 7);
    if (kind == 0) begin
      repeat (4) text_q.push_back(hex_char(4'hF));
    end else if (kind == 1) begin
      text_q.push_back("0");
    end else begin
      ndig = $urandom_range(1, 4);
      repeat (ndig) text_q.push_back(hex_char(4'($urandom_range(0, 15))));
    end
  endtask

  task automatic build_wellformed();
    int n;
    int pos;
    text_q.delete();
    if ($urandom_range(0, 3) != 0) begin
      n   = ($urandom_range(0, 9) == 0) ? v6p_pkg::MAX_GROUPS : $urandom_range(0, 7);
      pos = $urandom_range(0, n);
      for (int i = 0; i < pos; i++) begin
        push_group();
        if (i < pos - 1) text_q.push_back(v6p_pkg::CHAR_COLON);
      end
      text_q.push_back(v6p_pkg::CHAR_COLON);
      text_q.push_back(v6p_pkg::CHAR_COLON);
      for (int i = pos; i < n; i++) begin
        push_group();
        if (i < n - 1) text_q.push_back(v6p_pkg::CHAR_COLON);
      end
    end else begin
      for (int i = 0; i < v6p_pkg::MAX_GROUPS; i++) begin
        push_group();
        if (i < v6p_pkg::MAX_GROUPS - 1) text_q.push_back(v6p_pkg::CHAR_COLON);
      end
    end
  endtask

  function automatic logic [7:0] noise_char();
    int k;
    k = $urandom_range(0, 9);
    if (k < 4) return hex_char(4'($urandom_range(0, 15)));
    if (k < 6) return v6p_pkg::CHAR_COLON;
    if (k == 6) return "%";
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic build_broken();
    build_wellformed();
    case ($urandom_range(0, 5))
      0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(1, 255));
      1: text_q.insert($urandom_range(0, text_q.size()), noise_char());
      2: text_q.delete($urandom_range(0, text_q.size() - 1));
      3: begin
        text_q.push_back(v6p_pkg::CHAR_COLON);
        push_group();
      end
      4: text_q.push_back(v6p_pkg::CHAR_COLON);
      default: begin
        text_q.push_front(v6p_pkg::CHAR_COLON);
        text_q.push_back("%");
        text_q.push_back(noise_char());
      end
    endcase
  endtask

  task automatic build_noise();
    int len;
    text_q.delete();
    len = $urandom_range(0, 10);
    repeat (len) text_q.push_back(noise_char());
  endtask

  initial begin
    int pick;
    int base;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_char_code = 8'h00;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty, gap only, lone leading colon, five digits, second gap,
    // triple colon, trailing colon, zone index with a high byte ignored after it
    send_literal("");
    send_literal("::");
    send_literal(":1");
    send_literal("aBcD1");
    send_literal("::e::");
    send_literal(":::");
    send_literal("1:");
    send_literal({"%", 8'hFF});

    base = chars_sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          rcv_stall_pct   = 0;
          hold_cycles     = 300;
        end
        1: begin
          sender_idle_pct = 70;
          rcv_stall_pct   = 0;
        end
        2: begin
          sender_idle_pct = 0;
          rcv_stall_pct   = 70;
        end
        default: begin
          sender_idle_pct = 19;
          rcv_stall_pct   = 19;
        end
      endcase
      while (chars_sent - base < (ph + 1) * CHAR_TARGET / 4) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) build_wellformed();
        else if (pick < 80) build_broken();
        else build_noise();
        send_text();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (awaiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d texts in %0d characters over four idle/stall phases",
             texts_sent, chars_sent);
    $display("checked %0d address results, %0d of them valid, %0d failures",
             addr_checked, addr_good, err_count);
    if (err_count == 0 && awaiting == 0 && addr_checked == texts_sent) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/v6p_pkg.sv
hw/rtl/v6p_front.sv
hw/rtl/v6p_queue.sv
hw/rtl/v6p_scan.sv
hw/rtl/ipv6_text_address_parser_unit.sv
test/ipv6_text_address_parser_checker.sv
test/ipv6_text_address_parser_unit_tb.sv
